// File: src/wma_pkg.sv
// ----------------------------------------------------------------------------
// Weighted moving average package
// Shared widths, payload structs and the request structs that pass between
// the sequencer and its serial arithmetic units.
// ----------------------------------------------------------------------------
package wma_pkg;

	localparam int MAX_WINDOW  = 256;
	localparam int SAMPLE_BITS = 32;
	localparam int WLEN_W      = 9;
	localparam int SLOT_W      = $clog2(MAX_WINDOW);
	localparam int PROD_W      = SAMPLE_BITS + WLEN_W;
	localparam int PLAIN_W     = SAMPLE_BITS + SLOT_W + 1;
	localparam int WEIGHT_W    = 48;
	localparam int DIVISOR_W   = 16;
	localparam int AVG_W       = 32;
	localparam int MUL_STEPS   = WLEN_W;
	localparam int DIV_STEPS   = WEIGHT_W;
	localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	// Register index, taken from paddr above the byte offset.
	localparam logic [APB_AW-3:0] REG_WINDOW_LENGTH = 1'b0;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               last_of_series;
	} item_t;

	typedef struct packed {
		logic signed [31:0] average;
		logic               series_end;
	} result_t;

	typedef struct packed {
		logic                   start;
		logic [SAMPLE_BITS-1:0] multiplicand;
		logic [WLEN_W-1:0]      multiplier;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] product;
	} mul_rsp_t;

	typedef struct packed {
		logic                 start;
		logic                 negative;
		logic [WEIGHT_W-1:0]  magnitude;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [AVG_W-1:0] quotient;
	} div_rsp_t;

	// Window length as used: zero counts as one, large values saturate.
	function automatic logic [WLEN_W-1:0] eff_window(input logic [WLEN_W-1:0] v);
		logic [WLEN_W-1:0] w;
		w = v;
		if (v == '0) begin
			w = WLEN_W'(1);
		end else if (v > WLEN_W'(MAX_WINDOW)) begin
			w = WLEN_W'(MAX_WINDOW);
		end
		return w;
	endfunction

	// Sum of the weights 1..w, that is w(w+1)/2.
	function automatic logic [DIVISOR_W-1:0] weight_sum(input logic [WLEN_W-1:0] w);
		logic [2*WLEN_W-1:0] p;
		p = {{WLEN_W{1'b0}}, w} * ({{WLEN_W{1'b0}}, w} + (2*WLEN_W)'(1));
		return p[DIVISOR_W:1];
	endfunction

endpackage

// File: src/wma_ring.sv
// ----------------------------------------------------------------------------
// Sample ring
// Single-port store of the samples in the window. A read returns the entry as
// it was before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module wma_ring (
	input  logic                           clk,
	input  logic                           we,
	input  logic                           re,
	input  logic [wma_pkg::SLOT_W-1:0]      addr,
	input  logic [wma_pkg::SAMPLE_BITS-1:0] wdata,
	output logic [wma_pkg::SAMPLE_BITS-1:0] rdata
);
	import wma_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/wma_serial_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add product of a signed sample and an unsigned weight, one bit of
// the weight per cycle.
// ----------------------------------------------------------------------------
module wma_serial_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  wma_pkg::mul_req_t req,
	output wma_pkg::mul_rsp_t rsp
);
	import wma_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    acc_q;
	logic [PROD_W-1:0]    mcand_q;
	logic [WLEN_W-1:0]    mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));
			if (req.start) begin
				busy_q   <= 1'b1;
				cnt_q    <= '0;
				acc_q    <= '0;
				mcand_q  <= {{(PROD_W-SAMPLE_BITS){req.multiplicand[SAMPLE_BITS-1]}},
					req.multiplicand};
				mplier_q <= req.multiplier;
			end else if (busy_q) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[WLEN_W-1:1]};
				cnt_q    <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

// File: src/wma_serial_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Radix-2 restoring division of the weighted total's magnitude by the weight
// sum, one quotient bit per cycle, with the sign applied at the end.
// ----------------------------------------------------------------------------
module wma_serial_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wma_pkg::div_req_t req,
	output wma_pkg::div_rsp_t rsp
);
	import wma_pkg::*;

	logic                 busy_q;
	logic                 fin_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [WEIGHT_W-1:0]  dq_q;
	logic [DIVISOR_W:0]   trial;
	logic                 fits;

	// The dividend leaves the top of dq_q as quotient bits enter at the bottom.
	always_comb begin
		trial = {rem_q, dq_q[WEIGHT_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			dq_q   <= '0;
		end else begin
			fin_q <= !req.start && busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.negative;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
				dq_q   <= req.magnitude;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= DIVISOR_W'(trial - {1'b0, dvs_q});
				end else begin
					rem_q <= trial[DIVISOR_W-1:0];
				end
				dq_q  <= {dq_q[WEIGHT_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done     = fin_q;
	assign rsp.quotient = neg_q ? (AVG_W'(0) - dq_q[AVG_W-1:0]) : dq_q[AVG_W-1:0];

endmodule

// File: src/weighted_moving_average_core.sv
// ----------------------------------------------------------------------------
// Weighted moving average core
// Linearly weighted moving average over a window of up to 256 samples.
// A sample passes through the 9-step serial multiplier and, if it gives a
// result, the 48-step radix-2 divider; one that gives no result frees the
// block once its product is added in. No new sample is taken until the last
// is done, and a waiting result holds the block. Reset clears the window and
// sets the window length to one; the sample store itself is not cleared.
// ----------------------------------------------------------------------------
module weighted_moving_average_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wma_pkg::APB_AW-1:0]   paddr,
	input  logic [wma_pkg::APB_DW-1:0]   pwdata,
	output logic [wma_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  wma_pkg::item_t               item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output wma_pkg::result_t             result
);
	import wma_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                 state_q;
	logic [WLEN_W-1:0]      wlen_q;
	logic [WLEN_W-1:0]      weff_q;
	logic [DIVISOR_W-1:0]   divisor_q;
	logic [WLEN_W-1:0]      fill_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [PLAIN_W-1:0]     plain_q;
	logic [WEIGHT_W-1:0]    weighted_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   last_q;
	logic                   filling_q;
	logic                   produce_q;
	logic                   result_valid_q;
	result_t                result_q;

	logic                   accept;
	logic                   cfg_we;
	logic [WLEN_W-1:0]      cfg_wlen;
	logic [SLOT_W-1:0]      slot_sel;
	logic                   filling;
	logic [WLEN_W-1:0]      fill_inc;
	logic [WLEN_W-1:0]      slot_next;
	logic [SAMPLE_BITS-1:0] oldest;
	logic [PLAIN_W-1:0]     sample_ext;
	logic [PLAIN_W-1:0]     oldest_ext;
	logic [WEIGHT_W-1:0]    plain_wide;
	logic [WEIGHT_W-1:0]    prod_wide;
	mul_req_t               mul_req;
	mul_rsp_t               mul_rsp;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	always_comb begin
		accept    = item_valid && item_ready;
		cfg_we    = psel && penable && pwrite && pready &&
			(paddr[APB_AW-1:2] == REG_WINDOW_LENGTH);
		cfg_wlen  = pwdata[WLEN_W-1:0];
		slot_sel  = ({1'b0, slot_q} >= weff_q) ? '0 : slot_q;
		filling   = fill_q < weff_q;
		fill_inc  = fill_q + 1'b1;
		slot_next = {1'b0, slot_sel} + 1'b1;

		sample_ext = {{(PLAIN_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
		oldest_ext = {{(PLAIN_W-SAMPLE_BITS){oldest[SAMPLE_BITS-1]}}, oldest};
		plain_wide = {{(WEIGHT_W-PLAIN_W){plain_q[PLAIN_W-1]}}, plain_q};
		prod_wide  = {{(WEIGHT_W-PROD_W){mul_rsp.product[PROD_W-1]}}, mul_rsp.product};

		mul_req.start        = accept;
		mul_req.multiplicand = item.sample;
		mul_req.multiplier   = filling ? fill_inc : weff_q;

		div_req.start     = (state_q == ST_FIN) && produce_q;
		div_req.negative  = weighted_q[WEIGHT_W-1];
		div_req.magnitude = weighted_q[WEIGHT_W-1] ? (WEIGHT_W'(0) - weighted_q) : weighted_q;
		div_req.divisor   = divisor_q;
	end

	assign pready       = 1'b1;
	assign prdata       = (paddr[APB_AW-1:2] == REG_WINDOW_LENGTH) ? APB_DW'(wlen_q) : '0;
	// A register write takes the idle cycle, so no request is taken alongside it.
	assign item_ready   = (state_q == ST_IDLE) && !cfg_we;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	wma_ring u_ring (
		.clk   (clk),
		.we    (accept),
		.re    (accept),
		.addr  (slot_sel),
		.wdata (item.sample),
		.rdata (oldest)
	);

	wma_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	wma_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			wlen_q         <= WLEN_W'(1);
			weff_q         <= WLEN_W'(1);
			divisor_q      <= DIVISOR_W'(1);
			fill_q         <= '0;
			slot_q         <= '0;
			plain_q        <= '0;
			weighted_q     <= '0;
			sample_q       <= '0;
			last_q         <= 1'b0;
			filling_q      <= 1'b0;
			produce_q      <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready && (state_q != ST_OUT)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						wlen_q     <= cfg_wlen;
						weff_q     <= eff_window(cfg_wlen);
						divisor_q  <= weight_sum(eff_window(cfg_wlen));
						fill_q     <= '0;
						slot_q     <= '0;
						plain_q    <= '0;
						weighted_q <= '0;
					end else if (accept) begin
						sample_q  <= item.sample;
						last_q    <= item.last_of_series;
						filling_q <= filling;
						produce_q <= filling ? (fill_inc >= weff_q) : 1'b1;
						slot_q    <= (slot_next >= weff_q) ? '0 : slot_next[SLOT_W-1:0];
						if (filling) begin
							fill_q <= fill_inc;
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_rsp.done) begin
						// Sliding on: every held weight drops by one, which takes
						// the plain total off before the newest sample is added.
						if (filling_q) begin
							plain_q    <= plain_q + sample_ext;
							weighted_q <= weighted_q + prod_wide;
						end else begin
							plain_q    <= plain_q - oldest_ext + sample_ext;
							weighted_q <= weighted_q - plain_wide + prod_wide;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (last_q) begin
						fill_q     <= '0;
						slot_q     <= '0;
						plain_q    <= '0;
						weighted_q <= '0;
					end
					state_q <= produce_q ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!result_valid_q || result_ready) begin
						result_q.average    <= div_rsp.quotient;
						result_q.series_end <= last_q;
						result_valid_q      <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/wma_checker.sv
// ----------------------------------------------------------------------------
// Weighted moving average checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module wma_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [wma_pkg::APB_AW-1:0] paddr,
	input logic [wma_pkg::APB_DW-1:0] pwdata,
	input logic [wma_pkg::APB_DW-1:0] prdata,
	input logic                       pready,
	input logic                       item_valid,
	input logic                       item_ready,
	input wma_pkg::item_t             item,
	input logic                       result_valid,
	input logic                       result_ready,
	input wma_pkg::result_t           result
);
	import wma_pkg::*;

	// A waiting result must not change or vanish.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("result changed while stalled");

	// The core works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("second request taken while busy");

	// No result may come out straight after a request is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (!$rose(result_valid) ##1 !$rose(result_valid)))
		else $error("result appeared too early after a request");

	// A read of the window length never shows bits beyond its width.
	a_prdata_width: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && !pwrite) |-> (prdata[APB_DW-1:WLEN_W] == '0))
		else $error("read data exceeds register width");

endmodule

bind weighted_moving_average_core wma_checker u_wma_checker (.*);
